[rtl/core/tssu_pkg.sv]
package tssu_pkg;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	localparam logic [1:0] CFG_SITES_IN_USE = 2'd0;
	localparam logic [1:0] CFG_KEEP_WILD    = 2'd1;
	localparam logic [1:0] CFG_MUTATION     = 2'd2;

	localparam logic [10:0] SITES_RESET     = 11'd1024;
	localparam logic [31:0] KEEP_WILD_RESET = 32'd2526451350;
	localparam logic [31:0] MUTATION_RESET  = 32'd118111600;
	localparam logic [10:0] COUNT_MAX       = 11'd2047;

	typedef struct packed {
		logic        op;
		logic [9:0]  load_index;
		logic        load_mutant;
		logic [31:0] choice_draw;
		logic [31:0] mutation_draw;
	} in_item_t;

	typedef struct packed {
		logic [9:0]  site_index;
		logic        new_mutant;
		logic        at_boundary;
		logic        sweep_last;
		logic [10:0] wall_count;
		logic [10:0] wild_count;
	} out_item_t;

	// position sequencer flags for the site being issued
	typedef struct packed {
		logic last;     // final site of the sweep
		logic src_odd;  // sweep reads the odd buffer
	} seq_flags_t;

	// write port of the site store
	typedef struct packed {
		logic en;
		logic odd;
		logic data;
	} site_wr_t;

endpackage

[rtl/core/tssu_site_store.sv]
module tssu_site_store #(
	parameter int LATTICE_MAX = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic                           rd_odd,
	input  logic [$clog2(LATTICE_MAX)-1:0] rd_addr_a,
	input  logic [$clog2(LATTICE_MAX)-1:0] rd_addr_b,
	input  tssu_pkg::site_wr_t             wr,
	input  logic [$clog2(LATTICE_MAX)-1:0] wr_addr,
	output logic                           rd_data_a,
	output logic                           rd_data_b,
	output logic                           busy
);

	localparam int IW = $clog2(LATTICE_MAX);

	logic even_mem [LATTICE_MAX];
	logic odd_mem  [LATTICE_MAX];

	logic          busy_q;
	logic [IW-1:0] clr_addr_q;
	logic          rd_a_q;
	logic          rd_b_q;
	logic          fwd_a;
	logic          fwd_b;

	// clearing pass after reset, one entry of each buffer per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == IW'(LATTICE_MAX - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			even_mem[clr_addr_q] <= 1'b0;
			odd_mem[clr_addr_q]  <= 1'b0;
		end else if (wr.en) begin
			if (wr.odd) begin
				odd_mem[wr_addr] <= wr.data;
			end else begin
				even_mem[wr_addr] <= wr.data;
			end
		end
	end

	// write in the same cycle as a read of that entry: pass the new bit
	assign fwd_a = wr.en && (wr.odd == rd_odd) && (wr_addr == rd_addr_a);
	assign fwd_b = wr.en && (wr.odd == rd_odd) && (wr_addr == rd_addr_b);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= fwd_a ? wr.data : (rd_odd ? odd_mem[rd_addr_a] : even_mem[rd_addr_a]);
			rd_b_q <= fwd_b ? wr.data : (rd_odd ? odd_mem[rd_addr_b] : even_mem[rd_addr_b]);
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;
	assign busy      = busy_q;

endmodule

[rtl/core/tssu_seq.sv]
module tssu_seq #(
	parameter int LATTICE_MAX = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [10:0]                    sites_in_use,
	output logic [$clog2(LATTICE_MAX)-1:0] pos,
	output logic [$clog2(LATTICE_MAX)-1:0] nb,
	output tssu_pkg::seq_flags_t           flags
);

	localparam int IW = $clog2(LATTICE_MAX);
	localparam int RW = $clog2(LATTICE_MAX + 1);
	localparam int CW = (RW > 11) ? RW : 11;

	logic [IW-1:0] pos_q;
	logic          odd_q;
	logic [CW-1:0] siu_w;
	logic [CW-1:0] ring_c;
	logic [RW-1:0] ring;
	logic [IW-1:0] ring_top;
	logic [IW-1:0] cur;
	logic          last;

	// ring length clamped to 4..LATTICE_MAX
	always_comb begin
		siu_w = CW'(sites_in_use);
		if (siu_w < CW'(4)) begin
			ring_c = CW'(4);
		end else if (siu_w > CW'(LATTICE_MAX)) begin
			ring_c = CW'(LATTICE_MAX);
		end else begin
			ring_c = siu_w;
		end
	end

	assign ring     = ring_c[RW-1:0];
	assign ring_top = IW'(ring - 1'b1);
	assign cur      = (RW'(pos_q) >= ring) ? '0 : pos_q;
	assign last     = (RW'(cur) + 1'b1) == ring;

	always_comb begin
		if (odd_q) begin
			nb = (cur == '0) ? ring_top : cur - 1'b1;
		end else begin
			nb = last ? '0 : cur + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			odd_q <= 1'b1;
		end else if (step) begin
			if (last) begin
				pos_q <= '0;
				odd_q <= ~odd_q;
			end else begin
				pos_q <= cur + 1'b1;
			end
		end
	end

	assign pos           = cur;
	assign flags.last    = last;
	assign flags.src_odd = ~odd_q;

endmodule

[rtl/core/two_species_lattice_site_update_top.sv]
// Two-species ring lattice site update. Each item either loads one site
// (op 0) into the buffer the current sweep reads, or updates the next site of
// the running sweep (op 1); every item yields exactly one result item.
// Throughput is one item per clock unless the clearing pass or out_stall
// holds it: both site reads for an item go to the site RAM (registered
// read, two read ports) at accept, the update is computed from the read
// registers and written back while the next item's reads are issued, and a
// same-entry write/read overlap is forwarded inside the RAM. The result
// item passes through the stage 1 registers and then the output register;
// the output register lets a new item enter while a result still waits.
// After reset a clearing pass zeroes both site buffers, during which
// in_stall is high; configuration writes are taken at any time (cfg_ready
// is always high) but must only be issued while the block is idle. Sweep
// counts appear on the item with sweep_last.
module two_species_lattice_site_update_top #(
	parameter int LATTICE_MAX = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tssu_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output tssu_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int IW = $clog2(LATTICE_MAX);
	localparam int AW = (IW > 10) ? IW : 10;

	// configuration registers
	logic [10:0] sites_in_use_q;
	logic [31:0] keep_wild_q;
	logic [31:0] mutation_q;

	// handshake
	logic in_acc;
	logic s1_adv;
	logic busy;

	// sequencer
	logic                 step;
	logic [IW-1:0]        seq_pos;
	logic [IW-1:0]        seq_nb;
	tssu_pkg::seq_flags_t seq_flags;

	// load decode
	logic [AW-1:0] li_ext;
	logic [AW-1:0] pos_ext;
	logic          load_in_range;

	// stage 1: site reads in flight
	logic          s1_valid_q;
	logic          s1_op_s1;
	logic [9:0]    s1_index_s1;
	logic          s1_load_mutant_s1;
	logic [31:0]   s1_choice_s1;
	logic [31:0]   s1_mdraw_s1;
	logic          s1_last_s1;
	logic          s1_we_s1;
	logic          s1_wodd_s1;
	logic [IW-1:0] s1_waddr_s1;

	logic centre;
	logic neigh;

	// update arithmetic
	logic        boundary;
	logic        kept;
	logic        chosen;
	logic        result;
	logic [10:0] walls_q;
	logic [10:0] wild_q;
	logic [10:0] walls_nx;
	logic [10:0] wild_nx;
	logic        is_update;

	tssu_pkg::site_wr_t wr;

	tssu_pkg::out_item_t out_q;
	logic                out_valid_q;

	// ---------------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sites_in_use_q <= tssu_pkg::SITES_RESET;
			keep_wild_q    <= tssu_pkg::KEEP_WILD_RESET;
			mutation_q     <= tssu_pkg::MUTATION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tssu_pkg::CFG_SITES_IN_USE: sites_in_use_q <= cfg_data[10:0];
				tssu_pkg::CFG_KEEP_WILD:    keep_wild_q    <= cfg_data;
				tssu_pkg::CFG_MUTATION:     mutation_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// handshake: stage 1 moves on whenever the output register frees up
	// ---------------------------------------------------------------------
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = busy || (s1_valid_q && !s1_adv);
	assign in_acc   = in_valid && !in_stall;
	assign step     = in_acc && (in_item.op == tssu_pkg::OP_UPDATE);

	tssu_seq #(
		.LATTICE_MAX(LATTICE_MAX)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.sites_in_use(sites_in_use_q),
		.pos         (seq_pos),
		.nb          (seq_nb),
		.flags       (seq_flags)
	);

	// a load index past the lattice writes nothing but is still echoed
	assign li_ext        = AW'(in_item.load_index);
	assign pos_ext       = AW'(seq_pos);
	assign load_in_range = 32'(in_item.load_index) < 32'(LATTICE_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_op_s1          <= in_item.op;
			s1_load_mutant_s1 <= in_item.load_mutant;
			s1_choice_s1      <= in_item.choice_draw;
			s1_mdraw_s1       <= in_item.mutation_draw;
			if (in_item.op == tssu_pkg::OP_UPDATE) begin
				s1_index_s1 <= pos_ext[9:0];
				s1_last_s1  <= seq_flags.last;
				s1_we_s1    <= 1'b1;
				s1_wodd_s1  <= ~seq_flags.src_odd;
				s1_waddr_s1 <= seq_pos;
			end else begin
				// load goes into the buffer the current sweep reads
				s1_index_s1 <= in_item.load_index;
				s1_last_s1  <= 1'b0;
				s1_we_s1    <= load_in_range;
				s1_wodd_s1  <= seq_flags.src_odd;
				s1_waddr_s1 <= li_ext[IW-1:0];
			end
		end
	end

	// ---------------------------------------------------------------------
	// site buffers
	// ---------------------------------------------------------------------
	assign wr.en   = s1_adv && s1_we_s1;
	assign wr.odd  = s1_wodd_s1;
	assign wr.data = is_update ? result : s1_load_mutant_s1;

	tssu_site_store #(
		.LATTICE_MAX(LATTICE_MAX)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_acc),
		.rd_odd   (seq_flags.src_odd),
		.rd_addr_a(seq_pos),
		.rd_addr_b(seq_nb),
		.wr       (wr),
		.wr_addr  (s1_waddr_s1),
		.rd_data_a(centre),
		.rd_data_b(neigh),
		.busy     (busy)
	);

	// ---------------------------------------------------------------------
	// update: selection at a wall, then mutation of a wild result
	// ---------------------------------------------------------------------
	assign is_update = (s1_op_s1 == tssu_pkg::OP_UPDATE);
	assign boundary  = centre != neigh;

	// mutant centre kept below 2^32 - keep_wild, exact in 33 bits
	always_comb begin
		if (!centre) begin
			kept = s1_choice_s1 < keep_wild_q;
		end else begin
			kept = {1'b0, s1_choice_s1} < (33'h1_0000_0000 - {1'b0, keep_wild_q});
		end
		chosen = boundary ? (kept ? centre : neigh) : centre;
		result = chosen || (s1_mdraw_s1 < mutation_q);
	end

	assign walls_nx = (boundary && walls_q != tssu_pkg::COUNT_MAX) ? walls_q + 1'b1 : walls_q;
	assign wild_nx  = (!result && wild_q != tssu_pkg::COUNT_MAX) ? wild_q + 1'b1 : wild_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walls_q <= '0;
			wild_q  <= '0;
		end else if (s1_adv && is_update) begin
			if (s1_last_s1) begin
				walls_q <= '0;
				wild_q  <= '0;
			end else begin
				walls_q <= walls_nx;
				wild_q  <= wild_nx;
			end
		end
	end

	// ---------------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.site_index <= s1_index_s1;
			if (is_update) begin
				out_q.new_mutant  <= result;
				out_q.at_boundary <= boundary;
				out_q.sweep_last  <= s1_last_s1;
				out_q.wall_count  <= s1_last_s1 ? walls_nx : '0;
				out_q.wild_count  <= s1_last_s1 ? wild_nx : '0;
			end else begin
				out_q.new_mutant  <= s1_load_mutant_s1;
				out_q.at_boundary <= 1'b0;
				out_q.sweep_last  <= 1'b0;
				out_q.wall_count  <= '0;
				out_q.wild_count  <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_counts_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.sweep_last |-> out_item.wall_count == '0 && out_item.wild_count == '0)
		else $error("sweep counts shown on a result that does not end a sweep");

	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s1_valid_q && !wr.en)
		else $error("site write overlaps the clearing pass");

	a_counts_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && is_update && s1_last_s1 |=> walls_q == '0 && wild_q == '0)
		else $error("sweep counters not cleared after the last site");

	a_load_no_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && !is_update |=> !out_item.at_boundary && !out_item.sweep_last)
		else $error("load result flags a boundary or a sweep end");

endmodule
